// ===== rtl/awbc_pkg.sv =====
// Package for the ALU and micro-branch core: item structs, opcode and condition codes,
// and the operand-term function used by the first pipeline stage.
// Depends on nothing.
`timescale 1ns / 1ps

package awbc_pkg;

    typedef struct packed {
        logic [7:0] a_reg_one;
        logic [7:0] a_reg_zero;
        logic [7:0] b_reg_one;
        logic [7:0] b_reg_zero;
        logic       a_select;
        logic       b_select;
        logic [4:0] alu_op;
        logic       carry_in_n;
        logic [3:0] branch_op;
        logic       go_level;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic       negative;
        logic       all_ones;
        logic       zero_n;
        logic       carry_four;
        logic       carry_eight;
        logic       load_upc;
    } t_alu_out;

    typedef struct packed {
        logic [8:0] x;
        logic [8:0] y;
    } t_terms;

    localparam logic [3:0] ARITH_A_PLUS_ONE   = 4'd0;
    localparam logic [3:0] ARITH_OR_PLUS_ONE  = 4'd1;
    localparam logic [3:0] ARITH_ORN_PLUS_ONE = 4'd2;
    localparam logic [3:0] ARITH_MINUS_ONE    = 4'd3;
    localparam logic [3:0] ARITH_A_PLUS_ANDN  = 4'd4;
    localparam logic [3:0] ARITH_OR_PLUS_ANDN = 4'd5;
    localparam logic [3:0] ARITH_A_MINUS_B    = 4'd6;
    localparam logic [3:0] ARITH_ANDN_MINUS   = 4'd7;
    localparam logic [3:0] ARITH_A_PLUS_AND   = 4'd8;
    localparam logic [3:0] ARITH_A_PLUS_B     = 4'd9;
    localparam logic [3:0] ARITH_ORN_PLUS_AND = 4'd10;
    localparam logic [3:0] ARITH_AND_MINUS    = 4'd11;
    localparam logic [3:0] ARITH_A_PLUS_A     = 4'd12;
    localparam logic [3:0] ARITH_OR_PLUS_A    = 4'd13;
    localparam logic [3:0] ARITH_ORN_PLUS_A   = 4'd14;
    localparam logic [3:0] ARITH_A_MINUS      = 4'd15;

    localparam logic [3:0] LOGIC_NOT_A   = 4'd0;
    localparam logic [3:0] LOGIC_NOR     = 4'd1;
    localparam logic [3:0] LOGIC_NA_AND  = 4'd2;
    localparam logic [3:0] LOGIC_ZERO    = 4'd3;
    localparam logic [3:0] LOGIC_NAND    = 4'd4;
    localparam logic [3:0] LOGIC_NOT_B   = 4'd5;
    localparam logic [3:0] LOGIC_XOR     = 4'd6;
    localparam logic [3:0] LOGIC_A_ANDN  = 4'd7;
    localparam logic [3:0] LOGIC_NA_OR   = 4'd8;
    localparam logic [3:0] LOGIC_XNOR    = 4'd9;
    localparam logic [3:0] LOGIC_B       = 4'd10;
    localparam logic [3:0] LOGIC_AND     = 4'd11;
    localparam logic [3:0] LOGIC_ONES    = 4'd12;
    localparam logic [3:0] LOGIC_A_ORN   = 4'd13;
    localparam logic [3:0] LOGIC_OR      = 4'd14;
    localparam logic [3:0] LOGIC_A       = 4'd15;

    localparam logic [2:0] COND_ALL_ONES = 3'd0;
    localparam logic [2:0] COND_NEGATIVE = 3'd1;
    localparam logic [2:0] COND_CARRY4   = 3'd2;
    localparam logic [2:0] COND_CARRY8   = 3'd3;
    localparam logic [2:0] COND_GO       = 3'd4;
    localparam logic [2:0] COND_ZERO_N   = 3'd5;

    // Every arithmetic code is rewritten as x + y + carry, with subtraction of one
    // folded into an all-ones y term.
    function automatic t_terms arith_terms(input logic [3:0] code, input logic [8:0] a,
                                           input logic [8:0] b);
        t_terms t;
        logic [8:0] nb;
        nb = ~b;
        case (code)
            ARITH_A_PLUS_ONE:   t = '{x: a,         y: 9'd0};
            ARITH_OR_PLUS_ONE:  t = '{x: a | b,     y: 9'd0};
            ARITH_ORN_PLUS_ONE: t = '{x: a | nb,    y: 9'd0};
            ARITH_MINUS_ONE:    t = '{x: 9'd0,      y: 9'h1ff};
            ARITH_A_PLUS_ANDN:  t = '{x: a,         y: a & nb};
            ARITH_OR_PLUS_ANDN: t = '{x: a | b,     y: a & nb};
            ARITH_A_MINUS_B:    t = '{x: a,         y: nb};
            ARITH_ANDN_MINUS:   t = '{x: a & nb,    y: 9'h1ff};
            ARITH_A_PLUS_AND:   t = '{x: a,         y: a & b};
            ARITH_A_PLUS_B:     t = '{x: a,         y: b};
            ARITH_ORN_PLUS_AND: t = '{x: a | nb,    y: a & b};
            ARITH_AND_MINUS:    t = '{x: a & b,     y: 9'h1ff};
            ARITH_A_PLUS_A:     t = '{x: a,         y: a};
            ARITH_OR_PLUS_A:    t = '{x: a | b,     y: a};
            ARITH_ORN_PLUS_A:   t = '{x: a | nb,    y: a};
            default:            t = '{x: a,         y: 9'h1ff};
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/alu_with_branch_condition_core.sv =====
// Top level of the ALU and micro-branch core: a three-stage pipeline of operand
// terms, addition, and flag and branch evaluation.
// Depends on awbc_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_data (t_alu_in)
// output    out        o_valid / i_stall    o_data (t_alu_out)
//
// Each item passes three register stages before it is offered on the output channel.
// A new item is accepted in every cycle while the output is not stalled.
// A stall holds each occupied stage with no empty stage ahead of it; items behind move up into empty stages.
// Reset clears the stage valid bits only.
module alu_with_branch_condition_core
    import awbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_alu_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_alu_out o_data
);

    logic       r_v1, r_v2, r_v3;
    logic       rdy1, rdy2, rdy3;

    t_terms     r_wide, n_wide;
    t_terms     r_nib, n_nib;
    logic       r_cy, r_arith, r_sub, r_go;
    logic [3:0] r_bop;
    logic [7:0] r_logic, n_logic;

    logic [7:0] r_res2;
    logic       r_c4, r_c8, r_go2;
    logic [3:0] r_bop2;
    logic [8:0] sum_wide;
    logic [4:0] sum_nib;

    t_alu_out   r_out, n_out;

    logic [7:0] a, b;
    logic       sub;
    t_terms     nib_full;

    assign rdy3    = !r_v3 || !i_stall;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_out;

    always_comb begin
        a        = i_data.a_select ? i_data.a_reg_one : i_data.a_reg_zero;
        b        = i_data.b_select ? i_data.b_reg_one : i_data.b_reg_zero;
        n_wide   = arith_terms(i_data.alu_op[3:0], {1'b0, a}, {1'b0, b});
        nib_full = arith_terms(i_data.alu_op[3:0], {5'd0, a[3:0]}, {5'd0, b[3:0]});
        n_nib    = '{x: {4'd0, nib_full.x[4:0]}, y: {4'd0, nib_full.y[4:0]}};
        sub      = i_data.alu_op[3:0] inside {ARITH_A_MINUS_B, ARITH_ANDN_MINUS,
                                               ARITH_AND_MINUS, ARITH_A_MINUS};
        case (i_data.alu_op[3:0])
            LOGIC_NOT_A:  n_logic = ~a;
            LOGIC_NOR:    n_logic = ~(a | b);
            LOGIC_NA_AND: n_logic = ~a & b;
            LOGIC_ZERO:   n_logic = 8'h00;
            LOGIC_NAND:   n_logic = ~(a & b);
            LOGIC_NOT_B:  n_logic = ~b;
            LOGIC_XOR:    n_logic = a ^ b;
            LOGIC_A_ANDN: n_logic = a & ~b;
            LOGIC_NA_OR:  n_logic = ~a | b;
            LOGIC_XNOR:   n_logic = ~(a ^ b);
            LOGIC_B:      n_logic = b;
            LOGIC_AND:    n_logic = a & b;
            LOGIC_ONES:   n_logic = 8'hff;
            LOGIC_A_ORN:  n_logic = a | ~b;
            LOGIC_OR:     n_logic = a | b;
            default:      n_logic = a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_wide  <= n_wide;
            r_nib   <= n_nib;
            r_cy    <= ~i_data.carry_in_n;
            r_arith <= ~i_data.alu_op[4];
            r_sub   <= sub;
            r_logic <= n_logic;
            r_bop   <= i_data.branch_op;
            r_go    <= i_data.go_level;
        end
    end

    assign sum_wide = r_wide.x + r_wide.y + {8'd0, r_cy};
    assign sum_nib  = r_nib.x[4:0] + r_nib.y[4:0] + {4'd0, r_cy};

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_res2 <= r_arith ? sum_wide[7:0] : r_logic;
            r_c4   <= r_arith ? (sum_nib[4] ^ ~r_sub) : 1'b1;
            r_c8   <= r_arith ? (sum_wide[8] ^ ~r_sub) : 1'b1;
            r_bop2 <= r_bop;
            r_go2  <= r_go;
        end
    end

    always_comb begin
        logic cond;
        logic pol;
        n_out.result      = r_res2;
        n_out.negative    = r_res2[7];
        n_out.all_ones    = (r_res2 == 8'hff);
        n_out.zero_n      = (r_res2 != 8'h00);
        n_out.carry_four  = r_c4;
        n_out.carry_eight = r_c8;
        pol = r_bop2[3];
        case (r_bop2[2:0])
            COND_ALL_ONES: cond = n_out.all_ones;
            COND_NEGATIVE: cond = n_out.negative;
            COND_CARRY4:   cond = r_c4;
            COND_CARRY8:   cond = r_c8;
            COND_GO:       cond = r_go2;
            COND_ZERO_N:   cond = n_out.zero_n;
            default:       cond = 1'b0;
        endcase
        n_out.load_upc = cond ^ pol;
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

endmodule

// ===== test/alu_with_branch_condition_core_tb.sv =====
// Testbench for alu_with_branch_condition_core: directed and random items are pushed
// through the valid/stall channels and every result is checked against a local predictor.
// Depends on awbc_pkg and the core RTL.
`timescale 1ns / 1ps

module alu_with_branch_condition_core_tb;
    import awbc_pkg::*;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_alu_in  i_data = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_alu_out o_data;

    t_alu_in  alu_in_pending[$];
    t_alu_out alu_out_due[$];
    int       drain_at[$];
    int       items_sent = 0;
    int       items_total = 0;
    int       mismatches = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    t_alu_out want;

    alu_with_branch_condition_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] arith_sum(input logic [3:0] code, input logic [31:0] a,
                                              input logic [31:0] b, input logic [31:0] c);
        logic [31:0] nb;
        nb = ~b;
        case (code)
            ARITH_A_PLUS_ONE:   return a + 32'd1 - c;
            ARITH_OR_PLUS_ONE:  return (a | b) + 32'd1 - c;
            ARITH_ORN_PLUS_ONE: return (a | nb) + 32'd1 - c;
            ARITH_MINUS_ONE:    return 32'd0 - c;
            ARITH_A_PLUS_ANDN:  return a + (a & nb) + 32'd1 - c;
            ARITH_OR_PLUS_ANDN: return (a | b) + (a & nb) + 32'd1 - c;
            ARITH_A_MINUS_B:    return a - b - c;
            ARITH_ANDN_MINUS:   return (a & nb) - c;
            ARITH_A_PLUS_AND:   return a + (a & b) + 32'd1 - c;
            ARITH_A_PLUS_B:     return a + b + 32'd1 - c;
            ARITH_ORN_PLUS_AND: return (a | nb) + (a & b) + 32'd1 - c;
            ARITH_AND_MINUS:    return (a & b) - c;
            ARITH_A_PLUS_A:     return a + a + 32'd1 - c;
            ARITH_OR_PLUS_A:    return (a | b) + a + 32'd1 - c;
            ARITH_ORN_PLUS_A:   return (a | nb) + a + 32'd1 - c;
            default:            return a - c;
        endcase
    endfunction

    function automatic logic [7:0] logic_byte(input logic [3:0] code, input logic [7:0] a,
                                              input logic [7:0] b);
        case (code)
            LOGIC_NOT_A:  return ~a;
            LOGIC_NOR:    return ~(a | b);
            LOGIC_NA_AND: return ~a & b;
            LOGIC_ZERO:   return 8'h00;
            LOGIC_NAND:   return ~(a & b);
            LOGIC_NOT_B:  return ~b;
            LOGIC_XOR:    return a ^ b;
            LOGIC_A_ANDN: return a & ~b;
            LOGIC_NA_OR:  return ~a | b;
            LOGIC_XNOR:   return ~(a ^ b);
            LOGIC_B:      return b;
            LOGIC_AND:    return a & b;
            LOGIC_ONES:   return 8'hff;
            LOGIC_A_ORN:  return a | ~b;
            LOGIC_OR:     return a | b;
            default:      return a;
        endcase
    endfunction

    function automatic t_alu_out compute_alu_out(input t_alu_in w);
        t_alu_out    r;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [31:0] full;
        logic [31:0] nib;
        logic        is_sub;
        logic        pol;
        a = w.a_select ? w.a_reg_one : w.a_reg_zero;
        b = w.b_select ? w.b_reg_one : w.b_reg_zero;
        r.carry_four = 1'b1;
        r.carry_eight = 1'b1;
        if (!w.alu_op[4]) begin
            full = arith_sum(w.alu_op[3:0], {24'd0, a}, {24'd0, b}, {31'd0, w.carry_in_n});
            nib = arith_sum(w.alu_op[3:0], {28'd0, a[3:0]}, {28'd0, b[3:0]},
                            {31'd0, w.carry_in_n});
            is_sub = (w.alu_op[3:0] == ARITH_A_MINUS_B) || (w.alu_op[3:0] == ARITH_ANDN_MINUS)
                  || (w.alu_op[3:0] == ARITH_AND_MINUS) || (w.alu_op[3:0] == ARITH_A_MINUS);
            r.result = full[7:0];
            r.carry_four = is_sub ? nib[4] : ~nib[4];
            r.carry_eight = is_sub ? full[8] : ~full[8];
        end else begin
            r.result = logic_byte(w.alu_op[3:0], a, b);
        end
        r.negative = r.result[7];
        r.all_ones = (r.result == 8'hff);
        r.zero_n = (r.result != 8'h00);
        pol = w.branch_op[3];
        case (w.branch_op[2:0])
            COND_ALL_ONES: r.load_upc = r.all_ones != pol;
            COND_NEGATIVE: r.load_upc = r.negative != pol;
            COND_CARRY4:   r.load_upc = r.carry_four != pol;
            COND_CARRY8:   r.load_upc = r.carry_eight != pol;
            COND_GO:       r.load_upc = w.go_level != pol;
            COND_ZERO_N:   r.load_upc = r.zero_n != pol;
            default:       r.load_upc = pol;
        endcase
        return r;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_operand();
        logic [7:0] corners[7];
        corners = '{8'h00, 8'hff, 8'h0f, 8'hf0, 8'h80, 8'h7f, 8'h01};
        if ($urandom_range(0, 9) < 7) return 8'($urandom);
        return corners[$urandom_range(0, 6)];
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t ns: %s expected %h, got %h", $time, name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                alu_out_due.push_back(compute_alu_out(i_data));
                items_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (drain_at.size() != 0 && items_sent == drain_at[0]) begin
                    i_valid <= 1'b0;
                    if (alu_out_due.size() == 0) drain_at.delete(0);
                end else if (send_gap != 0) begin
                    i_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (alu_in_pending.size() != 0) begin
                    i_data <= alu_in_pending.pop_front();
                    i_valid <= 1'b1;
                    send_gap <= pick_gap(items_sent >= 400 && items_sent < 600);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (alu_out_due.size() == 0) begin
                    $display("%0t ns: unexpected item, got %h", $time, o_data);
                    mismatches++;
                end else begin
                    want = alu_out_due.pop_front();
                    check_field("result", want.result, o_data.result);
                    check_field("negative", {7'd0, want.negative}, {7'd0, o_data.negative});
                    check_field("all_ones", {7'd0, want.all_ones}, {7'd0, o_data.all_ones});
                    check_field("zero_n", {7'd0, want.zero_n}, {7'd0, o_data.zero_n});
                    check_field("carry_four", {7'd0, want.carry_four},
                                {7'd0, o_data.carry_four});
                    check_field("carry_eight", {7'd0, want.carry_eight},
                                {7'd0, o_data.carry_eight});
                    check_field("load_upc", {7'd0, want.load_upc}, {7'd0, o_data.load_upc});
                end
            end
            if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                i_stall <= 1'b0;
                stall_left <= pick_gap(items_sent >= 400 && items_sent < 600);
            end
        end
    end

    initial begin
        t_alu_in w;
        // Every opcode once with extreme operands; the branch ops cycle through all sixteen.
        for (int op = 0; op < 32; op++) begin
            w.a_reg_one = 8'hff;
            w.a_reg_zero = 8'h00;
            w.b_reg_one = 8'h00;
            w.b_reg_zero = 8'hff;
            w.a_select = op[1];
            w.b_select = op[2];
            w.alu_op = 5'(op);
            w.carry_in_n = op[3] ^ op[0];
            w.branch_op = op[3:0];
            w.go_level = op[4];
            alu_in_pending.push_back(w);
        end
        for (int n = 0; n < 1100; n++) begin
            w.a_reg_one = pick_operand();
            w.a_reg_zero = pick_operand();
            w.b_reg_one = pick_operand();
            w.b_reg_zero = pick_operand();
            w.a_select = 1'($urandom);
            w.b_select = 1'($urandom);
            w.alu_op = 5'($urandom_range(0, 31));
            w.carry_in_n = 1'($urandom);
            w.branch_op = 4'($urandom_range(0, 15));
            w.go_level = 1'($urandom);
            alu_in_pending.push_back(w);
        end
        items_total = alu_in_pending.size();
        drain_at.push_back(32);
        drain_at.push_back(750);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (items_sent < items_total || alu_out_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("alu_with_branch_condition_core regression: pass");
        end else begin
            $display("alu_with_branch_condition_core regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t ns: timeout", $time);
        $display("alu_with_branch_condition_core regression: fail");
        $finish;
    end

endmodule
